>>> sv/lmsl_pkg.sv
// ----------------------------------------------------------------------------
// lmsl_pkg
// Shared types, widths, request codes and state codes for the lightmap
// compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package lmsl_pkg;

  // sizes
  localparam int MAX_TEXELS = 4096;
  localparam int ADDR_W     = $clog2(MAX_TEXELS);
  localparam int CNT_W      = $clog2(MAX_TEXELS + 1);
  localparam int CFG_W      = 13;
  localparam int IDX_W      = 12;
  localparam int CHAN_W     = 8;
  localparam int LIGHT_W    = 12;
  localparam int SHADOW_W   = 8;
  localparam int PROD_W     = LIGHT_W + SHADOW_W;
  localparam int SUM_W      = ADDR_W + CHAN_W;
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  // constants
  localparam logic [CHAN_W-1:0] FILL_ALPHA = 8'd128;
  localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
  localparam int                ROUND_HALF = 128;

  // request codes
  localparam logic [2:0] REQ_FILL  = 3'd0;
  localparam logic [2:0] REQ_WRITE = 3'd1;
  localparam logic [2:0] REQ_COPY  = 3'd2;
  localparam logic [2:0] REQ_ADD   = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;
  localparam logic [2:0] REQ_MEAN  = 3'd5;

  // controller state codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_FILL = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_DIVS = 3'd4;
  localparam logic [2:0] ST_DIVW = 3'd5;
  localparam logic [2:0] ST_HOLD = 3'd6;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [SUM_W-1:0]  sum_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } texel_t;

  typedef struct packed {
    texel_t texel;
    logic   bad;
  } result_t;

endpackage

`default_nettype wire

>>> sv/lmsl_ram.sv
// ----------------------------------------------------------------------------
// lmsl_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/lmsl_div.sv
// ----------------------------------------------------------------------------
// lmsl_div
// Restoring divider, one quotient bit per cycle, three channel lanes that
// share one divisor and one step counter.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsl_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire lmsl_pkg::sum_t [2:0]          dividend_i,
  input  wire logic [lmsl_pkg::CNT_W-1:0]    divisor_i,
  output      logic                          done_o,
  output      lmsl_pkg::chan_t [2:0]         quotient_o
);

  import lmsl_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]     divisor_q;
  logic [CNT_W-1:0]     rem_q [3];
  logic [CNT_W-1:0]     rem_d [3];
  sum_t                 quo_q [3];
  sum_t                 quo_d [3];
  logic [CNT_W:0]       rem_sh [3];

  // step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      step_d = step_q + DIV_CNT_W'(1);
      if (step_q == DIV_CNT_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // one shift and conditional subtract per lane
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_sh[l] = {rem_q[l], quo_q[l][SUM_W-1]};
      rem_d[l]  = rem_q[l];
      quo_d[l]  = quo_q[l];
      if (start_i) begin
        rem_d[l] = '0;
        quo_d[l] = dividend_i[l];
      end else if (busy_q) begin
        if (rem_sh[l] >= {1'b0, divisor_q}) begin
          rem_d[l] = CNT_W'(rem_sh[l] - {1'b0, divisor_q});
          quo_d[l] = {quo_q[l][SUM_W-2:0], 1'b1};
        end else begin
          rem_d[l] = CNT_W'(rem_sh[l]);
          quo_d[l] = {quo_q[l][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      divisor_q <= divisor_i;
    end
    for (int l = 0; l < 3; l++) begin
      rem_q[l] <= rem_d[l];
      quo_q[l] <= quo_d[l];
    end
  end

  assign done_o = done_q;

  // quotients never exceed one channel
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      quotient_o[l] = quo_q[l][CHAN_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> sv/lightmap_saturating_light_compose.sv
// ----------------------------------------------------------------------------
// lightmap_saturating_light_compose
// Static and composed RGBA lightmaps with saturating additive light.
// ----------------------------------------------------------------------------
// Requests are handled one at a time; the next request is taken as soon as
// the previous result sits in the output register, even if it is not yet
// taken. Write, add light, read, an out-of-range index and an unknown code
// go from the accepting idle state to the EXEC state, where the result is
// written to the output register or parked: add light reads the real texel
// from its RAM, then rounds, saturates and writes it back. Fill writes n
// static texels; copy and mean read n static texels, and mean then runs a
// 20-step bit-serial divide, where n is texel_count clamped to 1..4096; the
// RAM ports move one texel per cycle. The texel stores are two 4096 x 32
// RAMs with no reset and no clearing pass: a texel must be written (by fill,
// write or copy) before it is read.
`default_nettype none

module lightmap_saturating_light_compose (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request channel
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic [2:0]                      req_type_i,
  input  wire logic [lmsl_pkg::IDX_W-1:0]      texel_index_i,
  input  wire lmsl_pkg::chan_t                 red_i,
  input  wire lmsl_pkg::chan_t                 green_i,
  input  wire lmsl_pkg::chan_t                 blue_i,
  input  wire lmsl_pkg::chan_t                 alpha_i,
  input  wire logic [lmsl_pkg::SHADOW_W-1:0]   shadow_i,
  input  wire logic [lmsl_pkg::LIGHT_W-1:0]    light_red_i,
  input  wire logic [lmsl_pkg::LIGHT_W-1:0]    light_green_i,
  input  wire logic [lmsl_pkg::LIGHT_W-1:0]    light_blue_i,
  // result channel
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      lmsl_pkg::chan_t                 out_red_o,
  output      lmsl_pkg::chan_t                 out_green_o,
  output      lmsl_pkg::chan_t                 out_blue_o,
  output      lmsl_pkg::chan_t                 out_alpha_o,
  output      logic                            bad_index_o,
  // texel count register
  input  wire logic                            cfg_we_i,
  input  wire logic [lmsl_pkg::CFG_W-1:0]      cfg_wdata_i
);

  import lmsl_pkg::*;

  localparam int TEX_W = $bits(texel_t);

  // round a 12.8 product, add it to the channel and clip at full scale
  function automatic chan_t sat_add(chan_t chan, logic [PROD_W-1:0] prod);
    logic [PROD_W:0]   rnd;
    logic [PROD_W-7:0] sum;
    rnd = {1'b0, prod} + (PROD_W + 1)'(ROUND_HALF);
    sum = (PROD_W - 6)'(rnd[PROD_W:8]) + (PROD_W - 6)'(chan);
    if (sum > (PROD_W - 6)'(CHAN_MAX)) begin
      return CHAN_MAX;
    end
    return sum[CHAN_W-1:0];
  endfunction

  logic [2:0]        state_q, state_d;
  logic [CFG_W-1:0]  cfg_q;
  logic [CNT_W-1:0]  used_n;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              rv_q, rv_d;
  logic [ADDR_W-1:0] ra_q;
  logic [2:0]        req_q;
  logic              bad_q;
  logic              bad_in;
  texel_t            col_q;
  logic [ADDR_W-1:0] idx_q;
  logic [PROD_W-1:0] prod_q [3];
  sum_t              acc_q [3];
  sum_t              acc_d [3];
  result_t           out_q, out_d;
  result_t           hold_q, hold_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              out_free;
  logic              fin;
  logic              issue;
  result_t           res;
  texel_t            lit;

  // memory ports
  logic              st_we, st_re, rl_we, rl_re;
  logic [ADDR_W-1:0] st_waddr, st_raddr, rl_waddr, rl_raddr;
  texel_t            st_wdata, rl_wdata, st_rdata, rl_rdata;

  // mean divider
  logic              div_start;
  logic              div_done;
  sum_t  [2:0]       div_dividend;
  chan_t [2:0]       div_quot;

  // clamp the texel count to 1..MAX_TEXELS
  always_comb begin
    if (cfg_q == '0) begin
      used_n = CNT_W'(1);
    end else if (int'(cfg_q) > MAX_TEXELS) begin
      used_n = CNT_W'(MAX_TEXELS);
    end else begin
      used_n = CNT_W'(cfg_q);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // index check for single-texel requests
  assign bad_in = ((req_type_i == REQ_WRITE) || (req_type_i == REQ_ADD) ||
                   (req_type_i == REQ_READ)) &&
                  (CNT_W'(texel_index_i) >= used_n);

  // read-modify result of add light
  always_comb begin
    lit.red   = sat_add(rl_rdata.red,   prod_q[0]);
    lit.green = sat_add(rl_rdata.green, prod_q[1]);
    lit.blue  = sat_add(rl_rdata.blue,  prod_q[2]);
    lit.alpha = rl_rdata.alpha;
  end

  assign issue = (cnt_q != used_n);

  // controller
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rv_d        = 1'b0;
    fin         = 1'b0;
    res         = '0;
    div_start   = 1'b0;
    st_we       = 1'b0;
    st_waddr    = idx_q;
    st_wdata    = col_q;
    st_re       = 1'b0;
    st_raddr    = cnt_q[ADDR_W-1:0];
    rl_we       = 1'b0;
    rl_waddr    = idx_q;
    rl_wdata    = lit;
    rl_re       = 1'b0;
    rl_raddr    = ADDR_W'(texel_index_i);
    out_d       = out_q;
    hold_d      = hold_q;
    out_valid_d = out_valid_q && !out_ready_i;
    for (int l = 0; l < 3; l++) begin
      acc_d[l] = acc_q[l];
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d = '0;
          for (int l = 0; l < 3; l++) begin
            acc_d[l] = '0;
          end
          case (req_type_i)
            REQ_FILL: state_d = ST_FILL;
            REQ_COPY: state_d = ST_WALK;
            REQ_MEAN: state_d = ST_WALK;
            REQ_ADD,
            REQ_READ: begin
              rl_re   = 1'b1;
              state_d = ST_EXEC;
            end
            default:  state_d = ST_EXEC;
          endcase
        end
      end

      // single-texel requests, real texel data is ready now
      ST_EXEC: begin
        fin     = 1'b1;
        res.bad = bad_q;
        if (!bad_q) begin
          case (req_q)
            REQ_WRITE: begin
              st_we     = 1'b1;
              res.texel = col_q;
            end
            REQ_ADD: begin
              rl_we     = 1'b1;
              res.texel = lit;
            end
            REQ_READ: res.texel = rl_rdata;
            default:  res.texel = '0;
          endcase
        end
      end

      // one static texel per cycle
      ST_FILL: begin
        st_we          = 1'b1;
        st_waddr       = cnt_q[ADDR_W-1:0];
        st_wdata.alpha = FILL_ALPHA;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == used_n - CNT_W'(1)) begin
          fin = 1'b1;
        end
      end

      // pipelined static read, then copy or accumulate
      ST_WALK: begin
        if (issue) begin
          st_re = 1'b1;
          cnt_d = cnt_q + CNT_W'(1);
        end
        rv_d = issue;
        if (rv_q) begin
          if (req_q == REQ_COPY) begin
            rl_we    = 1'b1;
            rl_waddr = ra_q;
            rl_wdata = st_rdata;
          end else begin
            acc_d[0] = acc_q[0] + SUM_W'(st_rdata.red);
            acc_d[1] = acc_q[1] + SUM_W'(st_rdata.green);
            acc_d[2] = acc_q[2] + SUM_W'(st_rdata.blue);
          end
          if (!issue) begin
            if (req_q == REQ_COPY) begin
              fin = 1'b1;
            end else begin
              state_d = ST_DIVS;
            end
          end
        end
      end

      ST_DIVS: begin
        div_start = 1'b1;
        state_d   = ST_DIVW;
      end

      ST_DIVW: begin
        if (div_done) begin
          fin             = 1'b1;
          res.texel.red   = div_quot[0];
          res.texel.green = div_quot[1];
          res.texel.blue  = div_quot[2];
        end
      end

      // result waits for the output register
      ST_HOLD: begin
        if (out_free) begin
          out_d       = hold_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // hand the result to the output register or park it
    if (fin) begin
      if (out_free) begin
        out_d       = res;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end else begin
        hold_d  = res;
        state_d = ST_HOLD;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CFG_W'(MAX_TEXELS);
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  // request capture and datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_type_i;
      bad_q     <= bad_in;
      idx_q     <= ADDR_W'(texel_index_i);
      col_q     <= '{red: red_i, green: green_i, blue: blue_i, alpha: alpha_i};
      prod_q[0] <= PROD_W'(light_red_i) * PROD_W'(shadow_i);
      prod_q[1] <= PROD_W'(light_green_i) * PROD_W'(shadow_i);
      prod_q[2] <= PROD_W'(light_blue_i) * PROD_W'(shadow_i);
    end
    ra_q   <= cnt_q[ADDR_W-1:0];
    out_q  <= out_d;
    hold_q <= hold_d;
    for (int l = 0; l < 3; l++) begin
      acc_q[l] <= acc_d[l];
    end
  end

  // static lightmap
  lmsl_ram #(
    .WIDTH (TEX_W),
    .DEPTH (MAX_TEXELS)
  ) u_static_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // composed real lightmap
  lmsl_ram #(
    .WIDTH (TEX_W),
    .DEPTH (MAX_TEXELS)
  ) u_real_ram (
    .clk_i   (clk_i),
    .we_i    (rl_we),
    .waddr_i (rl_waddr),
    .wdata_i (rl_wdata),
    .re_i    (rl_re),
    .raddr_i (rl_raddr),
    .rdata_o (rl_rdata)
  );

  // mean colour divider
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      div_dividend[l] = acc_q[l];
    end
  end

  lmsl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (used_n),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // output register
  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_q.texel.red;
  assign out_green_o = out_q.texel.green;
  assign out_blue_o  = out_q.texel.blue;
  assign out_alpha_o = out_q.texel.alpha;
  assign bad_index_o = out_q.bad;

endmodule

`default_nettype wire

>>> sv/lmsl_chk.sv
// ----------------------------------------------------------------------------
// lmsl_chk
// Port-level checks on the lightmap compositor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsl_chk (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_ready_o,
  input  wire logic [2:0]                      req_type_i,
  input  wire logic [lmsl_pkg::IDX_W-1:0]      texel_index_i,
  input  wire lmsl_pkg::chan_t                 red_i,
  input  wire lmsl_pkg::chan_t                 green_i,
  input  wire lmsl_pkg::chan_t                 blue_i,
  input  wire lmsl_pkg::chan_t                 alpha_i,
  input  wire logic [lmsl_pkg::SHADOW_W-1:0]   shadow_i,
  input  wire logic [lmsl_pkg::LIGHT_W-1:0]    light_red_i,
  input  wire logic [lmsl_pkg::LIGHT_W-1:0]    light_green_i,
  input  wire logic [lmsl_pkg::LIGHT_W-1:0]    light_blue_i,
  input  wire logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  input  wire lmsl_pkg::chan_t                 out_red_o,
  input  wire lmsl_pkg::chan_t                 out_green_o,
  input  wire lmsl_pkg::chan_t                 out_blue_o,
  input  wire lmsl_pkg::chan_t                 out_alpha_o,
  input  wire logic                            bad_index_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [lmsl_pkg::CFG_W-1:0]      cfg_wdata_i
);

  import lmsl_pkg::*;

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_red_o) &&
      $stable(out_green_o) && $stable(out_blue_o) && $stable(out_alpha_o) &&
      $stable(bad_index_o))
    else $error("result changed while stalled");

  // a rejected index carries no colour
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_index_o |-> out_red_o == '0 && out_green_o == '0 &&
      out_blue_o == '0 && out_alpha_o == '0)
    else $error("bad index result has colour");

  // one request in work at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in work");

  // a new result only ends a busy period
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a request in work");

endmodule

bind lightmap_saturating_light_compose lmsl_chk u_lmsl_chk (.*);

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for lightmap_saturating_light_compose. Requests
// go in through a valid/ready driver fed from a backlog queue, and results
// come out through a monitor with random back-pressure. A behavioral
// predictor keeps its own static and real maps. It computes each result
// when the request is accepted. The run sweeps the texel count through its
// extremes and several small settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmsl_pkg::*;

  // request codes with no defined meaning
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [2:0]          req;
    logic [IDX_W-1:0]    idx;
    chan_t               red;
    chan_t               green;
    chan_t               blue;
    chan_t               alpha;
    logic [SHADOW_W-1:0] shadow;
    logic [LIGHT_W-1:0]  light_red;
    logic [LIGHT_W-1:0]  light_green;
    logic [LIGHT_W-1:0]  light_blue;
  } lm_req_t;

  // dut ports
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [2:0]          req_type_i    = '0;
  logic [IDX_W-1:0]    texel_index_i = '0;
  chan_t               red_i         = '0;
  chan_t               green_i       = '0;
  chan_t               blue_i        = '0;
  chan_t               alpha_i       = '0;
  logic [SHADOW_W-1:0] shadow_i      = '0;
  logic [LIGHT_W-1:0]  light_red_i   = '0;
  logic [LIGHT_W-1:0]  light_green_i = '0;
  logic [LIGHT_W-1:0]  light_blue_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  chan_t               out_red_o;
  chan_t               out_green_o;
  chan_t               out_blue_o;
  chan_t               out_alpha_o;
  logic                bad_index_o;
  logic                cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata_i   = '0;

  // predictor state
  texel_t           static_map [MAX_TEXELS];
  texel_t           real_map   [MAX_TEXELS];
  logic [CFG_W-1:0] count_reg = 13'd4096;

  // request backlog and expected results
  lm_req_t req_backlog [$];
  result_t expected_texels [$];
  lm_req_t cur_req;
  result_t got, want;

  int queued_cnt   = 0;
  int accepted_cnt = 0;
  int checked_cnt  = 0;
  int fail_cnt     = 0;
  int send_gap     = 0;
  int stall_left   = 0;
  int calm_left    = 0;
  int count_phases = 0;
  int op_seen [8]  = '{default: 0};

  lightmap_saturating_light_compose DUT (.*);

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("lightmap_saturating_light_compose verification failed");
    $finish;
  end

  // count in use: zero acts as one, large values clamp to the map size
  function automatic int unsigned used_texels(logic [CFG_W-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > MAX_TEXELS) return MAX_TEXELS;
    return cnt;
  endfunction

  // one channel plus rounded light times shadow, saturating
  function automatic chan_t lit_channel(chan_t base, logic [LIGHT_W-1:0] light,
                                        logic [SHADOW_W-1:0] shade);
    int unsigned prod;
    int unsigned total;
    prod  = light * shade;
    total = base + ((prod + ROUND_HALF) >> 8);
    return (total > CHAN_MAX) ? CHAN_MAX : chan_t'(total);
  endfunction

  // predicted result of one request, updating the maps
  function automatic result_t compose_result(lm_req_t q);
    result_t     res;
    texel_t      t;
    int unsigned n;
    int unsigned i;
    int unsigned sum_r, sum_g, sum_b;
    res   = '0;
    n     = used_texels(count_reg);
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    if ((q.req == REQ_WRITE || q.req == REQ_ADD || q.req == REQ_READ) && q.idx >= n) begin
      res.bad = 1'b1;
      return res;
    end
    case (q.req)
      REQ_FILL: begin
        for (i = 0; i < n; i++) static_map[i] = {q.red, q.green, q.blue, FILL_ALPHA};
      end
      REQ_WRITE: begin
        t = {q.red, q.green, q.blue, q.alpha};
        static_map[q.idx] = t;
        res.texel = t;
      end
      REQ_COPY: begin
        for (i = 0; i < n; i++) real_map[i] = static_map[i];
      end
      REQ_ADD: begin
        t       = real_map[q.idx];
        t.red   = lit_channel(t.red, q.light_red, q.shadow);
        t.green = lit_channel(t.green, q.light_green, q.shadow);
        t.blue  = lit_channel(t.blue, q.light_blue, q.shadow);
        real_map[q.idx] = t;
        res.texel = t;
      end
      REQ_READ: begin
        res.texel = real_map[q.idx];
      end
      REQ_MEAN: begin
        for (i = 0; i < n; i++) begin
          sum_r += static_map[i].red;
          sum_g += static_map[i].green;
          sum_b += static_map[i].blue;
        end
        res.texel.red   = chan_t'(sum_r / n);
        res.texel.green = chan_t'(sum_g / n);
        res.texel.blue  = chan_t'(sum_b / n);
      end
      default: ;
    endcase
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_idle();
    int unsigned r;
    if (calm_left != 0) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic chan_t pick_chan();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CHAN_MAX;
      default: return chan_t'($urandom);
    endcase
  endfunction

  // light values weighted toward small and unit intensities
  function automatic logic [LIGHT_W-1:0] pick_light();
    case ($urandom_range(9))
      0:             return '0;
      1:             return '1;
      2:             return LIGHT_W'($urandom_range(300, 200));
      3, 4, 5, 6:    return LIGHT_W'($urandom_range(64));
      default:       return LIGHT_W'($urandom);
    endcase
  endfunction

  // request with the given code and index, all other fields random
  function automatic lm_req_t any_req(logic [2:0] code, logic [IDX_W-1:0] idx);
    lm_req_t q;
    q.req         = code;
    q.idx         = idx;
    q.red         = chan_t'($urandom);
    q.green       = chan_t'($urandom);
    q.blue        = chan_t'($urandom);
    q.alpha       = chan_t'($urandom);
    q.shadow      = SHADOW_W'($urandom);
    q.light_red   = LIGHT_W'($urandom);
    q.light_green = LIGHT_W'($urandom);
    q.light_blue  = LIGHT_W'($urandom);
    return q;
  endfunction

  // random request for a map of n texels, map walks kept rare on big maps
  function automatic lm_req_t random_req(int unsigned n);
    lm_req_t     q;
    int unsigned pick;
    int unsigned walk;
    q    = any_req(REQ_READ, '0);
    walk = (n > 256) ? 1 : 6;
    pick = $urandom_range(99);
    if (pick < walk) q.req = REQ_FILL;
    else if (pick < 2 * walk) q.req = REQ_COPY;
    else if (pick < 3 * walk) q.req = REQ_MEAN;
    else if (pick < 3 * walk + 3) q.req = $urandom_range(1) ? REQ_RSVD6 : REQ_RSVD7;
    else if (pick < 3 * walk + 25) q.req = REQ_WRITE;
    else if (pick < 3 * walk + 60) q.req = REQ_ADD;
    if (n < MAX_TEXELS && $urandom_range(99) < 15) begin
      q.idx = IDX_W'($urandom_range(MAX_TEXELS - 1, n));
    end else begin
      q.idx = IDX_W'($urandom_range(n - 1));
    end
    q.red         = pick_chan();
    q.green       = pick_chan();
    q.blue        = pick_chan();
    q.alpha       = pick_chan();
    q.shadow      = pick_chan();
    q.light_red   = pick_light();
    q.light_green = pick_light();
    q.light_blue  = pick_light();
    return q;
  endfunction

  task automatic queue_req(lm_req_t q);
    req_backlog.push_back(q);
    queued_cnt++;
  endtask

  // wait until every request is accepted and every result is back
  task automatic settle();
    while (accepted_cnt != queued_cnt || expected_texels.size() != 0) @(posedge clk_i);
  endtask

  // texel count write, only while the block is idle
  task automatic set_count(logic [CFG_W-1:0] v);
    settle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    count_reg    = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    count_phases++;
  endtask

  // one count setting: fill and copy so every texel in use is written
  task automatic random_phase(logic [CFG_W-1:0] v, int items);
    int unsigned n;
    n = used_texels(v);
    set_count(v);
    queue_req(any_req(REQ_FILL, IDX_W'($urandom)));
    queue_req(any_req(REQ_COPY, IDX_W'($urandom)));
    repeat (items) queue_req(random_req(n));
    queue_req(any_req(REQ_MEAN, IDX_W'($urandom)));
  endtask

  // stretches with no idling on either side
  always @(posedge clk_i) begin
    if (calm_left != 0) begin
      calm_left <= calm_left - 1;
    end else if ($urandom_range(299) == 0) begin
      calm_left <= $urandom_range(200, 40);
    end
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_texels.push_back(compose_result(cur_req));
        op_seen[cur_req.req]++;
        accepted_cnt++;
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the request until it is taken
      end else if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (req_backlog.size() != 0) begin
        cur_req        = req_backlog.pop_front();
        in_valid_i    <= 1'b1;
        req_type_i    <= cur_req.req;
        texel_index_i <= cur_req.idx;
        red_i         <= cur_req.red;
        green_i       <= cur_req.green;
        blue_i        <= cur_req.blue;
        alpha_i       <= cur_req.alpha;
        shadow_i      <= cur_req.shadow;
        light_red_i   <= cur_req.light_red;
        light_green_i <= cur_req.light_green;
        light_blue_i  <= cur_req.light_blue;
        send_gap      <= pick_idle();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.texel = {out_red_o, out_green_o, out_blue_o, out_alpha_o};
        got.bad   = bad_index_o;
        if (expected_texels.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("%0t: result with no request pending: rgba %0d %0d %0d %0d bad %0b",
                     $realtime, got.texel.red, got.texel.green, got.texel.blue,
                     got.texel.alpha, got.bad);
          end
        end else begin
          want = expected_texels.pop_front();
          checked_cnt++;
          if (got.texel.red !== want.texel.red || got.texel.green !== want.texel.green ||
              got.texel.blue !== want.texel.blue || got.texel.alpha !== want.texel.alpha ||
              got.bad !== want.bad) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS) begin
              $display("%0t: result %0d mismatch: exp rgba %0d %0d %0d %0d bad %0b",
                       $realtime, checked_cnt, want.texel.red, want.texel.green,
                       want.texel.blue, want.texel.alpha, want.bad);
              $display("    got rgba %0d %0d %0d %0d bad %0b", got.texel.red,
                       got.texel.green, got.texel.blue, got.texel.alpha, got.bad);
            end
          end
        end
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= stall_left - 1;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(5) == 0) stall_left <= pick_idle();
      end
    end
  end

  // stimulus
  initial begin
    lm_req_t q;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full map at the reset count: fill, mean, and extreme texels
    q = any_req(REQ_FILL, '0);
    q.red = 8'd255; q.green = 8'd0; q.blue = 8'd170;
    queue_req(q);
    queue_req(any_req(REQ_COPY, IDX_W'($urandom)));
    queue_req(any_req(REQ_MEAN, IDX_W'($urandom)));
    q = any_req(REQ_WRITE, '1);
    q.red = 8'd0; q.green = 8'd255; q.blue = 8'd85; q.alpha = 8'd255;
    queue_req(q);
    q = any_req(REQ_WRITE, '0);
    q.red = 8'd255; q.green = 8'd255; q.blue = 8'd255; q.alpha = 8'd0;
    queue_req(q);
    queue_req(any_req(REQ_MEAN, IDX_W'($urandom)));
    queue_req(any_req(REQ_COPY, IDX_W'($urandom)));
    queue_req(any_req(REQ_READ, '1));
    queue_req(any_req(REQ_READ, '0));
    // saturation from full light, no change at zero shadow
    q = any_req(REQ_ADD, '0);
    q.shadow = '1; q.light_red = '1; q.light_green = '1; q.light_blue = '1;
    queue_req(q);
    q = any_req(REQ_ADD, '1);
    q.shadow = '0; q.light_red = '1; q.light_green = '1; q.light_blue = '1;
    queue_req(q);
    q = any_req(REQ_ADD, '1);
    q.shadow = '1; q.light_red = '0; q.light_green = 12'd128; q.light_blue = 12'd1;
    queue_req(q);
    // rounding on a black texel: half rounds up, just under half rounds down
    q = any_req(REQ_WRITE, 12'd1);
    q.red = '0; q.green = '0; q.blue = '0; q.alpha = 8'd7;
    queue_req(q);
    queue_req(any_req(REQ_COPY, IDX_W'($urandom)));
    q = any_req(REQ_ADD, 12'd1);
    q.shadow = 8'd1; q.light_red = 12'd128; q.light_green = 12'd127; q.light_blue = 12'd384;
    queue_req(q);
    queue_req(any_req(REQ_RSVD6, '1));
    queue_req(any_req(REQ_RSVD7, '1));

    // single texel: indices past it are flagged
    set_count(13'd1);
    queue_req(any_req(REQ_FILL, IDX_W'($urandom)));
    queue_req(any_req(REQ_COPY, IDX_W'($urandom)));
    queue_req(any_req(REQ_WRITE, '0));
    queue_req(any_req(REQ_WRITE, 12'd1));
    queue_req(any_req(REQ_ADD, '1));
    queue_req(any_req(REQ_READ, 12'd2));
    queue_req(any_req(REQ_READ, '0));
    queue_req(any_req(REQ_MEAN, IDX_W'($urandom)));
    repeat (40) queue_req(random_req(1));

    // zero and oversized counts clamp
    random_phase(13'd0, 30);
    random_phase('1, 25);

    // small maps carry most of the random traffic
    repeat (5) random_phase(CFG_W'($urandom_range(64, 2)), 45);
    random_phase(CFG_W'($urandom_range(300, 65)), 60);
    random_phase(13'd4096, 20);

    settle();
    repeat (64) @(posedge clk_i);

    $display("%0d requests over %0d count settings, %0d results checked, %0d failures",
             accepted_cnt, count_phases + 1, checked_cnt, fail_cnt);
    $display("fill %0d write %0d copy %0d add %0d read %0d mean %0d unused codes %0d",
             op_seen[REQ_FILL], op_seen[REQ_WRITE], op_seen[REQ_COPY], op_seen[REQ_ADD],
             op_seen[REQ_READ], op_seen[REQ_MEAN], op_seen[REQ_RSVD6] + op_seen[REQ_RSVD7]);
    if (fail_cnt == 0) begin
      $display("lightmap_saturating_light_compose verification clean");
    end else begin
      $display("lightmap_saturating_light_compose verification failed");
    end
    $finish;
  end

endmodule
